/* src/pipw_pkg.sv */
// package for the point in polygon winding unit
// holds codes, default sizes and the edge unit control struct; no dependencies

package pipw_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned COORD_BITS_DEF   = 16;

  // fewest vertices that make a polygon
  localparam int unsigned MIN_VERTICES = 3;

  // result winding field and its saturation limits
  localparam int unsigned WINDING_BITS = 9;
  localparam int          WIND_MAX     = 255;
  localparam int          WIND_MIN     = -256;

  // item action codes
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_FEW  = 2'd2
  } status_e;

  // control of the shared edge unit
  typedef struct packed {
    logic load;
    logic mul_lhs;
    logic mul_rhs;
  } edge_ctl_t;

endpackage

/* src/pipw_if.sv */
// valid/ready channel interfaces of the point in polygon winding unit
// depends on pipw_pkg for the default coordinate width and field widths

interface pipw_in_if #(
  parameter int unsigned COORD_BITS = pipw_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;

  modport source (output valid, output action, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input action, input x_coord, input y_coord, output ready);
endinterface

interface pipw_out_if;
  import pipw_pkg::*;

  logic                           valid;
  logic                           ready;
  logic                           inside_res;
  logic signed [WINDING_BITS-1:0] winding;
  logic [1:0]                     status;

  modport source (output valid, output inside_res, output winding, output status, input ready);
  modport sink   (input valid, input inside_res, input winding, input status, output ready);
endinterface

/* src/point_in_polygon_winding_unit.sv */
// top level of the point in polygon winding unit: sequencer, vertex store, result register
// depends on pipw_pkg, pipw_if, pipw_ram and pipw_edge_unit

// Keeps a closed polygon of up to MAX_VERTICES vertices, loaded in order by append
// items and emptied by a clear item, and answers query items with the winding number
// of the point (exact integer cross products, closing edge included). Every item gives
// one result item. Clear, append, an unused action code and a query on fewer than three
// vertices give their result in the next cycle. A query keeps the input not ready
// until its closing edge is counted: the vertex ram gives one vertex per read, and
// each edge goes through a single shared multiplier twice before its cross sign is
// compared. A new item is taken in a cycle where the sequencer is idle and the
// result register is empty or being taken.

module point_in_polygon_winding_unit #(
  parameter int unsigned MAX_VERTICES = pipw_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pipw_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pipw_in_if.sink     in_i,
  pipw_out_if.source  out_o
);
  import pipw_pkg::*;

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned VW = 2 * COORD_BITS;
  localparam int unsigned WW = CW + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_LOAD = 6'b000100,
    ST_MUL1 = 6'b001000,
    ST_MUL2 = 6'b010000,
    ST_CMP  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic                 closing_q, closing_d;
  logic signed [WW-1:0] w_q, w_d;
  logic                 out_valid_q, out_valid_d;

  logic [VW-1:0]               a_q, a_d, first_q, first_d;
  logic signed [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic                        inside_q, inside_d;
  logic signed [WINDING_BITS-1:0] wind_q, wind_d;
  logic [1:0]                  status_q, status_d;

  logic          in_accept;
  logic          ram_we, ram_re;
  logic [VW-1:0] ram_rdata;
  logic [VW-1:0] b_word;
  logic [CW-1:0] idx_next;
  edge_ctl_t     ctl;
  logic          edge_inc, edge_dec;

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_accept  = in_i.valid && in_i.ready;

  // vertex store, written by append items, read once per vertex by a query
  assign ram_we = in_accept && (in_i.action == ACT_APPEND) &&
                  (count_q < CW'(MAX_VERTICES));
  assign ram_re = (state_q == ST_READ);

  pipw_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({in_i.x_coord, in_i.y_coord}),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // end vertex of the current edge: the first vertex on the closing edge
  assign b_word = closing_q ? first_q : ram_rdata;

  pipw_edge_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .ax_i  ($signed(a_q[VW-1:COORD_BITS])),
    .ay_i  ($signed(a_q[COORD_BITS-1:0])),
    .bx_i  ($signed(b_word[VW-1:COORD_BITS])),
    .by_i  ($signed(b_word[COORD_BITS-1:0])),
    .px_i  (px_q),
    .py_i  (py_q),
    .inc_o (edge_inc),
    .dec_o (edge_dec)
  );

  assign idx_next = idx_q + CW'(1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    closing_d   = closing_q;
    w_d         = w_q;
    out_valid_d = out_valid_q && !out_o.ready;
    a_d         = a_q;
    first_d     = first_q;
    px_d        = px_q;
    py_d        = py_q;
    inside_d    = inside_q;
    wind_d      = wind_q;
    status_d    = status_q;
    ctl         = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          inside_d = 1'b0;
          wind_d   = '0;
          status_d = STAT_OK;
          case (in_i.action)
            ACT_CLEAR: begin
              count_d     = '0;
              out_valid_d = 1'b1;
            end
            ACT_APPEND: begin
              if (count_q < CW'(MAX_VERTICES)) begin
                count_d = count_q + CW'(1);
              end else begin
                status_d = STAT_FULL;
              end
              out_valid_d = 1'b1;
            end
            ACT_QUERY: begin
              if (count_q < CW'(MIN_VERTICES)) begin
                status_d    = STAT_FEW;
                out_valid_d = 1'b1;
              end else begin
                px_d      = in_i.x_coord;
                py_d      = in_i.y_coord;
                idx_d     = '0;
                closing_d = 1'b0;
                w_d       = '0;
                state_d   = ST_READ;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if ((idx_q == '0) && !closing_q) begin
          // first vertex only opens the walk
          first_d = ram_rdata;
          a_d     = ram_rdata;
          idx_d   = idx_next;
          state_d = ST_READ;
        end else begin
          ctl.load = 1'b1;
          a_d      = b_word;
          state_d  = ST_MUL1;
        end
      end
      ST_MUL1: begin
        ctl.mul_lhs = 1'b1;
        state_d     = ST_MUL2;
      end
      ST_MUL2: begin
        ctl.mul_rhs = 1'b1;
        state_d     = ST_CMP;
      end
      ST_CMP: begin
        if (edge_inc) begin
          w_d = w_q + WW'(1);
        end else if (edge_dec) begin
          w_d = w_q - WW'(1);
        end
        if (closing_q) begin
          state_d = ST_IDLE;
        end else if (idx_next == count_q) begin
          closing_d = 1'b1;
          state_d   = ST_LOAD;
        end else begin
          idx_d   = idx_next;
          state_d = ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // query result once the closing edge is counted
    if ((state_q == ST_CMP) && closing_q) begin
      inside_d    = (w_d != '0);
      status_d    = STAT_OK;
      out_valid_d = 1'b1;
      if (32'(w_d) > WIND_MAX) begin
        wind_d = WINDING_BITS'(WIND_MAX);
      end else if (32'(w_d) < WIND_MIN) begin
        wind_d = WINDING_BITS'(WIND_MIN);
      end else begin
        wind_d = WINDING_BITS'(w_d);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      closing_q   <= 1'b0;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      closing_q   <= closing_d;
      w_q         <= w_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    first_q  <= first_d;
    px_q     <= px_d;
    py_q     <= py_d;
    inside_q <= inside_d;
    wind_q   <= wind_d;
    status_q <= status_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = inside_q;
  assign out_o.winding    = wind_q;
  assign out_o.status     = status_q;

endmodule

/* src/pipw_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies

module pipw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pipw_edge_unit.sv */
// shared edge unit: coordinate differences, one multiplier used twice, cross sign
// depends on pipw_pkg for edge_ctl_t

module pipw_edge_unit #(
  parameter int unsigned COORD_BITS = pipw_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  pipw_pkg::edge_ctl_t          ctl_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  output logic                         inc_o,
  output logic                         dec_o
);
  import pipw_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [DW-1:0] dx_ab_q, dy_ab_q, dx_ap_q, dy_ap_q;
  logic                 up_q, dn_q;
  logic signed [DW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] lhs_q, rhs_q;
  logic                 a_below;

  // edge direction against the point row
  assign a_below = (ay_i <= py_i);

  // differences and crossing flags of the edge
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      dx_ab_q <= DW'(bx_i) - DW'(ax_i);
      dy_ab_q <= DW'(by_i) - DW'(ay_i);
      dx_ap_q <= DW'(px_i) - DW'(ax_i);
      dy_ap_q <= DW'(py_i) - DW'(ay_i);
      up_q    <= a_below && (by_i > py_i);
      dn_q    <= !a_below && (by_i <= py_i);
    end
  end

  // one multiplier, operands picked by the step
  assign op_a = ctl_i.mul_rhs ? dx_ap_q : dx_ab_q;
  assign op_b = ctl_i.mul_rhs ? dy_ab_q : dy_ap_q;
  assign prod = op_a * op_b;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_lhs) begin
      lhs_q <= prod;
    end
    if (ctl_i.mul_rhs) begin
      rhs_q <= prod;
    end
  end

  // point left of upward edge counts up, right of downward edge counts down
  assign inc_o = up_q && (lhs_q > rhs_q);
  assign dec_o = dn_q && (lhs_q < rhs_q);

endmodule

/* src/pipw_checker.sv */
// port level checker for the point in polygon winding unit, bound to the top level
// depends on pipw_pkg for the action and status codes

module pipw_checker (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     in_valid_i,
  input logic                                     in_ready_i,
  input logic [1:0]                               in_action_i,
  input logic                                     out_valid_i,
  input logic                                     out_ready_i,
  input logic                                     out_inside_i,
  input logic signed [pipw_pkg::WINDING_BITS-1:0] out_winding_i,
  input logic [1:0]                               out_status_i
);
  import pipw_pkg::*;

  // a waiting result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped before it was taken");

  // new item only while the result register is free or draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> out_ready_i)
    else $error("input ready while a result item waits");

  // inside flag follows a nonzero winding number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_inside_i == (out_winding_i != '0)))
    else $error("inside flag does not match winding number");

  // a failed item reports outside with zero winding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != STAT_OK) |-> !out_inside_i && (out_winding_i == '0))
    else $error("error status with nonzero result");

  // clear answers in the next cycle with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ACT_CLEAR) |=>
      out_valid_i && (out_status_i == STAT_OK) && !out_inside_i)
    else $error("clear item gave no ok result");

endmodule

bind point_in_polygon_winding_unit pipw_checker u_pipw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_action_i   (in_i.action),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_inside_i  (out_o.inside_res),
  .out_winding_i (out_o.winding),
  .out_status_i  (out_o.status)
);

/* bench/point_in_polygon_winding_checker.sv */
// result checker for the point in polygon winding unit bench
// watches the item and result channels, keeps its own copy of the polygon and compares
// depends on pipw_pkg and the channel interfaces in pipw_if
`timescale 1ns / 100ps

module point_in_polygon_winding_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pipw_in_if          item_i,
  pipw_out_if         result_i,
  output int unsigned error_count_o,
  output int unsigned outstanding_o
);
  import pipw_pkg::*;

  localparam int unsigned MAX_VERTS   = MAX_VERTICES_DEF;
  localparam int unsigned CBITS       = COORD_BITS_DEF;
  localparam int unsigned PRINT_LIMIT = 100;

  typedef logic signed [CBITS-1:0] coord_t;

  typedef struct packed {
    logic                           in_poly;
    logic signed [WINDING_BITS-1:0] winding;
    status_e                        status;
  } verdict_t;

  // own copy of the stored polygon
  coord_t      poly_x [MAX_VERTS];
  coord_t      poly_y [MAX_VERTS];
  int unsigned poly_len = 0;

  verdict_t    pending_results [$];
  int unsigned result_num = 0;
  int unsigned mismatches = 0;
  int unsigned queued     = 0;

  assign error_count_o = mismatches;
  assign outstanding_o = queued;

  // sign of (b - a) x (p - a), exact in 64 bits
  function automatic int edge_side(input longint ax, input longint ay, input longint bx,
                                   input longint by, input longint px, input longint py);
    longint lhs;
    longint rhs;
    lhs = (bx - ax) * (py - ay);
    rhs = (px - ax) * (by - ay);
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  // applies one item to the polygon copy and returns the result it should give
  function automatic verdict_t winding_result(input logic [1:0] act, input coord_t px,
                                              input coord_t py);
    verdict_t    res;
    int          w;
    int unsigned j;
    longint      ax, ay, bx, by, qx, qy;
    res = '{in_poly: 1'b0, winding: '0, status: STAT_OK};
    qx  = px;
    qy  = py;
    case (act)
      ACT_CLEAR: begin
        poly_len = 0;
      end
      ACT_APPEND: begin
        if (poly_len < MAX_VERTS) begin
          poly_x[poly_len] = px;
          poly_y[poly_len] = py;
          poly_len++;
        end else begin
          res.status = STAT_FULL;
        end
      end
      ACT_QUERY: begin
        if (poly_len < MIN_VERTICES) begin
          res.status = STAT_FEW;
        end else begin
          w = 0;
          // every edge, the closing one included
          for (int unsigned i = 0; i < poly_len; i++) begin
            j  = (i + 1 == poly_len) ? 0 : i + 1;
            ax = poly_x[i];
            ay = poly_y[i];
            bx = poly_x[j];
            by = poly_y[j];
            if (ay <= qy) begin
              if (by > qy && edge_side(ax, ay, bx, by, qx, qy) > 0) w++;
            end else begin
              if (by <= qy && edge_side(ax, ay, bx, by, qx, qy) < 0) w--;
            end
          end
          res.in_poly = (w != 0);
          if (w > WIND_MAX) w = WIND_MAX;
          if (w < WIND_MIN) w = WIND_MIN;
          res.winding = w[WINDING_BITS-1:0];
        end
      end
      default: begin
        // spare action code leaves everything alone
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("mismatch at result %0d: %s", result_num, msg);
  endtask

  // compare finished results, then predict newly taken items
  always @(posedge clk_i) begin : watch
    verdict_t want;
    if (rst_ni) begin
      if (result_i.valid && result_i.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item waiting");
        end else begin
          want = pending_results.pop_front();
          if (result_i.inside_res !== want.in_poly)
            report_mismatch($sformatf("inside_res %0b, expected %0b",
                                      result_i.inside_res, want.in_poly));
          if (result_i.winding !== want.winding)
            report_mismatch($sformatf("winding %0d, expected %0d",
                                      $signed(result_i.winding), $signed(want.winding)));
          if (result_i.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result_i.status, want.status));
        end
        result_num++;
      end
      if (item_i.valid && item_i.ready)
        pending_results.insert(pending_results.size(),
                               winding_result(item_i.action, item_i.x_coord,
                                              item_i.y_coord));
      queued <= pending_results.size();
    end
  end

endmodule

/* bench/point_in_polygon_winding_unit_test.sv */
// top of the point in polygon winding unit bench: clock, reset, stimulus and verdict
// drives polygons and query points into the unit, idles both channels at random
// depends on pipw_pkg, pipw_if, the unit and point_in_polygon_winding_checker
`timescale 1ns / 100ps

module point_in_polygon_winding_unit_test;
  import pipw_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 800;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned MAX_VERTS       = MAX_VERTICES_DEF;
  localparam int unsigned FULL_RANGE      = 32768;
  localparam logic [1:0]  ACT_SPARE       = 2'd3;

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned error_count;
  int unsigned outstanding;

  // idling modes and the long receiver hold-off request
  logic tx_bursty    = 1'b0;
  logic rx_bursty    = 1'b0;
  logic hold_off_req = 1'b0;

  // vertices sent since the last clear, used to aim query points
  coord_t      shape_x [MAX_VERTS];
  coord_t      shape_y [MAX_VERTS];
  int unsigned shape_len  = 0;
  int unsigned items_sent = 0;

  pipw_in_if  item_ch ();
  pipw_out_if result_ch ();

  point_in_polygon_winding_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_ch),
    .out_o  (result_ch)
  );

  point_in_polygon_winding_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_ch),
    .result_i      (result_ch),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  // idle length: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // coordinate in [-span, span), now and then one of the extremes
  function automatic coord_t rand_coord(input int unsigned span);
    int v;
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0:       v = -32768;
        1:       v = 32767;
        2:       v = 0;
        default: v = -1;
      endcase
    end else begin
      v = int'($urandom_range(0, 2 * span - 1)) - int'(span);
    end
    return coord_t'(v);
  endfunction

  // offer one item and wait until it is taken
  task automatic send_item(input logic [1:0] act, input coord_t x, input coord_t y);
    int unsigned gap;
    gap = (tx_bursty && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid   <= 1'b1;
    item_ch.action  <= act;
    item_ch.x_coord <= x;
    item_ch.y_coord <= y;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    if (act != ACT_SPARE) items_sent++;
    if (act == ACT_CLEAR) begin
      shape_len = 0;
    end else if (act == ACT_APPEND && shape_len < MAX_VERTS) begin
      shape_x[shape_len] = x;
      shape_y[shape_len] = y;
      shape_len++;
    end
  endtask

  // query point: in the box, on a vertex, at one vertex's column and another's level, or anywhere on a vertex's level
  task automatic query_near(input int unsigned span);
    coord_t      qx, qy;
    int unsigned a, b;
    qx = rand_coord(span);
    qy = rand_coord(span);
    if (shape_len > 0) begin
      a = $urandom_range(0, shape_len - 1);
      b = $urandom_range(0, shape_len - 1);
      case ($urandom_range(0, 5))
        3: begin
          qx = shape_x[a];
          qy = shape_y[a];
        end
        4: begin
          qx = shape_x[a];
          qy = shape_y[b];
        end
        5: begin
          qx = rand_coord(FULL_RANGE);
          qy = shape_y[a];
        end
        default: ;
      endcase
    end
    send_item(ACT_QUERY, qx, qy);
  endtask

  // append n vertices: random ones in a box, or triangles looping the origin
  task automatic build_shape(input int unsigned n, input int unsigned span, input bit loops);
    coord_t x, y, prev_x, prev_y;
    int     r;
    bit     ccw;
    r      = $urandom_range(1, span - 1);
    ccw    = $urandom_range(0, 1);
    prev_x = '0;
    prev_y = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (loops) begin
        case (i % 3)
          0: begin
            x = coord_t'(ccw ? r : -r);
            y = coord_t'(-r);
          end
          1: begin
            x = '0;
            y = coord_t'(r);
          end
          default: begin
            x = coord_t'(ccw ? -r : r);
            y = coord_t'(-r);
          end
        endcase
      end else begin
        x = rand_coord(span);
        y = rand_coord(span);
        // horizontal edges and repeated vertices
        if (i > 0 && $urandom_range(0, 7) == 0) y = prev_y;
        if (i > 0 && $urandom_range(0, 15) == 0) x = prev_x;
      end
      send_item(ACT_APPEND, x, y);
      prev_x = x;
      prev_y = y;
    end
  endtask

  // result receiver with random stalls and one long hold-off on request
  initial begin : receiver
    result_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (rx_bursty && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned start, n, span, queries, pick;
    item_ch.valid   <= 1'b0;
    item_ch.action  <= ACT_CLEAR;
    item_ch.x_coord <= '0;
    item_ch.y_coord <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, then too few vertices
    send_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    send_item(ACT_APPEND, coord_t'(-32768), coord_t'(-32768));
    send_item(ACT_APPEND, coord_t'(32767), coord_t'(-32768));
    send_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    // widest triangle: inside, on vertices, on the bottom edge, outside
    send_item(ACT_APPEND, coord_t'(0), coord_t'(32767));
    send_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    send_item(ACT_QUERY, coord_t'(-32768), coord_t'(-32768));
    send_item(ACT_QUERY, coord_t'(0), coord_t'(-32768));
    send_item(ACT_QUERY, coord_t'(0), coord_t'(32767));
    send_item(ACT_QUERY, coord_t'(32767), coord_t'(32767));
    send_item(ACT_QUERY, coord_t'(-1), coord_t'(-1));
    // spare action code changes nothing
    send_item(ACT_SPARE, coord_t'(16'h5a5a), coord_t'(16'ha5a5));
    send_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    send_item(ACT_CLEAR, coord_t'(16'ha5a5), coord_t'(16'h5a5a));
    send_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    // square walked twice counter-clockwise, winding two
    repeat (2) begin
      send_item(ACT_APPEND, coord_t'(-100), coord_t'(-100));
      send_item(ACT_APPEND, coord_t'(100), coord_t'(-100));
      send_item(ACT_APPEND, coord_t'(100), coord_t'(100));
      send_item(ACT_APPEND, coord_t'(-100), coord_t'(100));
    end
    send_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    send_item(ACT_QUERY, coord_t'(100), coord_t'(0));

    // receiver holds off while items keep coming, input must stall
    hold_off_req = 1'b1;
    send_item(ACT_CLEAR, coord_t'(0), coord_t'(0));
    build_shape(3, 64, 1'b1);
    repeat (4) query_near(64);

    // full store: loops around the origin, appends past the end, long queries
    tx_bursty = 1'b1;
    rx_bursty = 1'b1;
    send_item(ACT_CLEAR, coord_t'(0), coord_t'(0));
    build_shape(MAX_VERTS, 30000, 1'b1);
    repeat (3) send_item(ACT_APPEND, rand_coord(FULL_RANGE), rand_coord(FULL_RANGE));
    repeat (3) query_near(50);
    query_near(FULL_RANGE);

    // random polygons followed by queries
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      tx_bursty = ($urandom_range(0, 3) != 0);
      rx_bursty = ($urandom_range(0, 3) != 0);
      // now and then keep the old polygon and grow it
      if ($urandom_range(0, 5) != 0)
        send_item(ACT_CLEAR, rand_coord(FULL_RANGE), rand_coord(FULL_RANGE));
      pick = $urandom_range(0, 99);
      if (pick < 10)      n = $urandom_range(0, 2);
      else if (pick < 80) n = $urandom_range(3, 10);
      else if (pick < 97) n = $urandom_range(11, 48);
      else                n = $urandom_range(100, MAX_VERTS);
      case ($urandom_range(0, 3))
        0:       span = 8;
        1:       span = 64;
        2:       span = 1024;
        default: span = FULL_RANGE;
      endcase
      build_shape(n, span, $urandom_range(0, 3) == 0);
      queries = (n > 48) ? 2 : $urandom_range(1, 6);
      repeat (queries) begin
        query_near(span);
        if ($urandom_range(0, 19) == 0)
          send_item(ACT_SPARE, rand_coord(FULL_RANGE), rand_coord(FULL_RANGE));
      end
    end

    // drain and verdict
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
